/* rtl/core/sorted_array_table_macros.svh */
// ----------------------------------------------------------------------------
// Sorted array table assertion macros
// Shared concurrent assertion forms, clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_TABLE_MACROS_SVH
`define SORTED_ARRAY_TABLE_MACROS_SVH

// same-cycle implication
`define SAT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sorted_array_table assertion failed");

// next-cycle implication
`define SAT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sorted_array_table assertion failed");

`endif

/* rtl/core/sat_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted array table package
// Default sizes, operation and status codes, controller command word.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int KEY_BITS_DEF     = 32;
    localparam int PAYLOAD_BITS_DEF = 32;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_READ   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BAD_POS = 2'd2
    } t_status;

    typedef struct packed {
        logic load;
        logic apply;
    } t_cmd;

endpackage

/* rtl/core/sat_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted array table controller
// Two-state sequencer: take a word, then commit it to the datapath.
// ----------------------------------------------------------------------------
module sat_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output sat_pkg::t_cmd o_cmd
);
    import sat_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_APPLY
    } t_state;

    t_state r_state;
    logic   r_busy;

    assign busy        = r_busy;
    assign o_cmd.load  = start && !r_busy;
    assign o_cmd.apply = (r_state == S_APPLY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_APPLY;
                        r_busy  <= 1'b1;
                    end
                end
                S_APPLY: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

endmodule

/* rtl/core/sat_dpath.sv */
// ----------------------------------------------------------------------------
// Sorted array table datapath
// Row of key/payload cells with parallel compare, insert shift and remove
// shift, entry count and registered result word.
// ----------------------------------------------------------------------------
`include "sorted_array_table_macros.svh"

module sat_dpath #(
    parameter int DEPTH        = sat_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = sat_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = sat_pkg::PAYLOAD_BITS_DEF,
    parameter int POS_BITS     = $clog2(DEPTH),
    parameter int CNT_BITS     = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sat_pkg::t_cmd           i_cmd,
    input  logic [1:0]              i_kind,
    input  logic [KEY_BITS-1:0]     i_new_key,
    input  logic [PAYLOAD_BITS-1:0] i_new_payload,
    input  logic [POS_BITS-1:0]     i_position,
    output logic                    o_done,
    output logic [1:0]              o_status,
    output logic [POS_BITS-1:0]     o_where_placed,
    output logic [KEY_BITS-1:0]     o_out_key,
    output logic [PAYLOAD_BITS-1:0] o_out_payload,
    output logic [CNT_BITS-1:0]     o_entry_count
);
    import sat_pkg::*;

    localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

    logic [KEY_BITS-1:0]     r_key [DEPTH];
    logic [PAYLOAD_BITS-1:0] r_pay [DEPTH];
    logic [KEY_BITS-1:0]     n_key [DEPTH];
    logic [PAYLOAD_BITS-1:0] n_pay [DEPTH];
    logic [DEPTH-1:0]        r_lt;
    logic [DEPTH-1:0]        n_lt;
    logic [DEPTH-1:0]        w_hit;
    logic [CNT_BITS-1:0]     r_count;
    logic [CNT_BITS-1:0]     n_count;

    t_kind                   r_kind;
    logic [KEY_BITS-1:0]     r_in_key;
    logic [PAYLOAD_BITS-1:0] r_in_pay;
    logic [POS_BITS-1:0]     r_pos;

    logic                    r_done;
    logic [1:0]              r_status;
    logic [POS_BITS-1:0]     r_placed;
    logic [KEY_BITS-1:0]     r_out_key;
    logic [PAYLOAD_BITS-1:0] r_out_pay;
    t_status                 n_status;
    logic [POS_BITS-1:0]     n_placed;
    logic [KEY_BITS-1:0]     n_out_key;
    logic [PAYLOAD_BITS-1:0] n_out_pay;

    logic w_full;
    logic w_bad;

    // compare every live cell against the incoming key
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_lt[i] = (CNT_BITS'(i) < r_count) && (r_key[i] < i_new_key);
        end
    end

    // first cell that is not below the new key
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i == 0) begin
                w_hit[i] = !r_lt[i];
            end else begin
                w_hit[i] = !r_lt[i] && r_lt[i-1];
            end
        end
    end

    assign w_full = (r_count == FULL_CNT);
    assign w_bad  = ({{(CNT_BITS-POS_BITS){1'b0}}, r_pos} >= r_count);

    always_comb begin
        n_placed = '0;
        for (int i = 0; i < DEPTH; i++) begin
            n_placed = n_placed | (w_hit[i] ? POS_BITS'(i) : '0);
        end

        for (int i = 0; i < DEPTH; i++) begin
            n_key[i] = r_key[i];
            n_pay[i] = r_pay[i];
        end
        n_count   = r_count;
        n_status  = ST_OK;
        n_out_key = '0;
        n_out_pay = '0;

        case (r_kind)
            KIND_INSERT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                    n_placed = '0;
                end else begin
                    for (int i = 0; i < DEPTH; i++) begin
                        if (w_hit[i]) begin
                            n_key[i] = r_in_key;
                            n_pay[i] = r_in_pay;
                        end else if (i > 0 && !r_lt[i-1]) begin
                            n_key[i] = r_key[i-1];
                            n_pay[i] = r_pay[i-1];
                        end
                    end
                    n_count = r_count + 1'b1;
                end
            end
            KIND_REMOVE, KIND_READ: begin
                n_placed = '0;
                if (w_bad) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_out_key = r_key[r_pos];
                    n_out_pay = r_pay[r_pos];
                    if (r_kind == KIND_REMOVE) begin
                        for (int i = 0; i < DEPTH - 1; i++) begin
                            if (POS_BITS'(i) >= r_pos) begin
                                n_key[i] = r_key[i+1];
                                n_pay[i] = r_pay[i+1];
                            end
                        end
                        n_count = r_count - 1'b1;
                    end
                end
            end
            default: begin
                n_placed = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.apply;
            if (i_cmd.apply) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= t_kind'(i_kind);
            r_in_key <= i_new_key;
            r_in_pay <= i_new_payload;
            r_pos    <= i_position;
            r_lt     <= n_lt;
        end
        if (i_cmd.apply) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_key[i] <= n_key[i];
                r_pay[i] <= n_pay[i];
            end
            r_status  <= n_status;
            r_placed  <= n_placed;
            r_out_key <= n_out_key;
            r_out_pay <= n_out_pay;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_where_placed = r_placed;
    assign o_out_key      = r_out_key;
    assign o_out_payload  = r_out_pay;
    assign o_entry_count  = r_count;

    `SAT_ASSERT_NOW(a_count_max, 1'b1, r_count <= FULL_CNT)
    `SAT_ASSERT_NOW(a_full_count, r_done && (r_status == ST_FULL), r_count == FULL_CNT)
    `SAT_ASSERT_NEXT(a_insert_grows, i_cmd.apply && (r_kind == KIND_INSERT) && !w_full,
        r_count == CNT_BITS'($past(r_count) + 1'b1))

endmodule

/* rtl/core/sorted_array_table.sv */
// ----------------------------------------------------------------------------
// Sorted array table
// Up to DEPTH key/payload entries kept in ascending key order; insert,
// remove at position and read at position.
// ----------------------------------------------------------------------------
// Raise start with a word while busy is low; the word is taken at that edge.
// busy is high for the next cycle, in which every cell has already compared
// its key and the table shifts; in the cycle after that o_done pulses for
// one cycle with the result, and busy is low again, so a new word may be
// started then. A word goes through the compare stage across all cells, then
// the shift stage. The result is on the ports from the o_done strobe until the
// next word applies, and cannot be held off; capture it then.
// ----------------------------------------------------------------------------
module sorted_array_table #(
    parameter int DEPTH        = sat_pkg::DEPTH_DEF,
    parameter int KEY_BITS     = sat_pkg::KEY_BITS_DEF,
    parameter int PAYLOAD_BITS = sat_pkg::PAYLOAD_BITS_DEF,
    parameter int POS_BITS     = $clog2(DEPTH),
    parameter int CNT_BITS     = $clog2(DEPTH + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_kind,
    input  logic [KEY_BITS-1:0]     i_new_key,
    input  logic [PAYLOAD_BITS-1:0] i_new_payload,
    input  logic [POS_BITS-1:0]     i_position,
    output logic                    o_done,
    output logic [1:0]              o_status,
    output logic [POS_BITS-1:0]     o_where_placed,
    output logic [KEY_BITS-1:0]     o_out_key,
    output logic [PAYLOAD_BITS-1:0] o_out_payload,
    output logic [CNT_BITS-1:0]     o_entry_count
);
    import sat_pkg::*;

    t_cmd w_cmd;

    sat_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    sat_dpath #(
        .DEPTH        (DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .POS_BITS     (POS_BITS),
        .CNT_BITS     (CNT_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_kind         (i_kind),
        .i_new_key      (i_new_key),
        .i_new_payload  (i_new_payload),
        .i_position     (i_position),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_where_placed (o_where_placed),
        .o_out_key      (o_out_key),
        .o_out_payload  (o_out_payload),
        .o_entry_count  (o_entry_count)
    );

endmodule
